FILE: sv/stsu_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window trend statistics package
// Widths, register indexes and the job record shared by the front part, the
// job queue and the back part of the trend statistics unit.
// ----------------------------------------------------------------------------
package stsu_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int MAX_WINDOW = 63;
   localparam int PTR_W      = 6;
   localparam int RING_DEPTH = 2 ** PTR_W;
   localparam int SEEN_W     = PTR_W + 1;
   localparam int WLEN_W     = 6;
   localparam int FACTOR_W   = 10;
   localparam int INC_W      = SAMPLE_W + 1;
   localparam int WSUM_W     = 30;
   localparam int WSQ_W      = 54;
   localparam int PIS_W      = 31;
   localparam int CSR_DATA_W = 10;

   // register indexes of the configuration port
   localparam logic CSR_WINDOW_LENGTH = 1'b0;
   localparam logic CSR_BAND_FACTOR   = 1'b1;

   // shared divider
   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 24;
   localparam int DIV_CNT_W = 6;

   // quotient bits needed for each division
   localparam logic [DIV_CNT_W-1:0] DIV_BITS_MEAN = 6'd32;
   localparam logic [DIV_CNT_W-1:0] DIV_BITS_REL  = 6'd31;
   localparam logic [DIV_CNT_W-1:0] DIV_BITS_STD  = 6'd32;
   localparam logic [DIV_CNT_W-1:0] DIV_BITS_DIST = 6'd35;

   // result limits
   localparam logic [23:0] STD_MAX    = 24'hFFFFFF;
   localparam logic [25:0] DIST_MAX   = 26'h3FFFFFF;
   localparam logic [15:0] REL_MAX    = 16'h7FFF;
   localparam logic [15:0] REL_MIN    = 16'h8000;
   localparam logic [15:0] SWITCH_MAX = 16'hFFFF;

   // one classified sample handed from the front part to the back part
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W-1:0] ref_sample;
      logic                inc_valid;
      logic                dev_valid;
      logic [WLEN_W-1:0]   period;
      logic [PIS_W-1:0]    pis;
      logic [WSUM_W-1:0]   wsum;
      logic [WSQ_W-1:0]    wsq;
   } job_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
      logic [DIV_CNT_W-1:0] nbits;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
      logic [DIV_DEN_W-1:0] rem;
   } div_rsp_type;

endpackage

FILE: sv/stsu_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/stsu_front.sv
// ----------------------------------------------------------------------------
// Trend statistics front part
// Accepts samples, keeps the sample and increase rings and the running sums,
// and hands one classified job per sample to the job queue.
// ----------------------------------------------------------------------------
module stsu_front import stsu_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                restart,
   input  logic [WLEN_W-1:0]   period,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,   // sample
   output logic                push_valid,
   input  logic                push_ready,
   output job_type             push_data
);

   localparam int SQ_W = 2 * SAMPLE_W;

   typedef enum logic [1:0] {F_IDLE, F_READ, F_UPD} front_state_type;

   front_state_type     state_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0] prev_ff;
   logic [SEEN_W-1:0]   seen_ff;
   logic [PTR_W-1:0]    ptr_ff;
   logic [WSUM_W-1:0]   wsum_ff;
   logic [WSQ_W-1:0]    wsq_ff;
   logic [PIS_W-1:0]    pis_ff;
   logic [2*SAMPLE_W-1:0] sq_new_ff;
   logic [2*SAMPLE_W-1:0] sq_old_ff;

   logic [PTR_W-1:0]    old_idx;
   logic [SAMPLE_W-1:0] ref_rd;
   logic [INC_W-1:0]    inc_rd;
   logic                has_ref;
   logic                has_prev;
   logic                drop_inc;
   logic [INC_W-1:0]    inc_new;
   logic [WSUM_W-1:0]   wsum_in;
   logic [WSQ_W-1:0]    wsq_in;
   logic [PIS_W-1:0]    pis_in;
   logic [SEEN_W-1:0]   seen_in;
   logic                do_update;

   // ring entry that leaves the window
   assign old_idx = ptr_ff - period;

   stsu_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_DEPTH)) u_sample_ring (
      .clock   (clock),
      .wr_en   (do_update),
      .wr_addr (ptr_ff),
      .wr_data (sample_ff),
      .rd_addr (old_idx),
      .rd_data (ref_rd)
   );

   stsu_ram #(.WIDTH(INC_W), .DEPTH(RING_DEPTH)) u_increase_ring (
      .clock   (clock),
      .wr_en   (do_update && has_prev),
      .wr_addr (ptr_ff),
      .wr_data (inc_new),
      .rd_addr (old_idx),
      .rd_data (inc_rd)
   );

   assign req_tready = (state_ff == F_IDLE);
   assign do_update  = (state_ff == F_UPD) && push_ready;
   assign push_valid = (state_ff == F_UPD);

   // classify against the fill level and update the running sums
   always_comb begin
      has_ref  = seen_ff >= {1'b0, period};
      has_prev = seen_ff != '0;
      drop_inc = (seen_ff >= ({1'b0, period} + 1'b1)) && !inc_rd[INC_W-1]
                 && (inc_rd != '0);
      inc_new  = {sample_ff[SAMPLE_W-1], sample_ff} - {prev_ff[SAMPLE_W-1], prev_ff};
      wsum_in  = wsum_ff + WSUM_W'($signed(sample_ff));
      wsq_in   = wsq_ff + WSQ_W'(sq_new_ff);
      if (has_ref) begin
         wsum_in = wsum_in - WSUM_W'($signed(ref_rd));
         wsq_in  = wsq_in - WSQ_W'(sq_old_ff);
      end
      pis_in = pis_ff;
      if (has_prev) begin
         if (drop_inc) begin
            pis_in = pis_in - PIS_W'(inc_rd);
         end
         if (!inc_new[INC_W-1] && (inc_new != '0)) begin
            pis_in = pis_in + PIS_W'(inc_new);
         end
      end
      seen_in = (seen_ff < SEEN_W'(RING_DEPTH)) ? seen_ff + 1'b1 : seen_ff;

      push_data.sample     = sample_ff;
      push_data.ref_sample = ref_rd;
      push_data.inc_valid  = has_ref;
      push_data.dev_valid  = (seen_ff + 1'b1) >= {1'b0, period};
      push_data.period     = period;
      push_data.pis        = pis_in;
      push_data.wsum       = wsum_in;
      push_data.wsq        = wsq_in;
   end

   // sequence one sample: read the leaving entry, square, update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         seen_ff  <= '0;
         ptr_ff   <= '0;
         prev_ff  <= '0;
         wsum_ff  <= '0;
         wsq_ff   <= '0;
         pis_ff   <= '0;
      end else if (restart) begin
         seen_ff <= '0;
         ptr_ff  <= '0;
         prev_ff <= '0;
         wsum_ff <= '0;
         wsq_ff  <= '0;
         pis_ff  <= '0;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (req_tvalid) begin
                  sample_ff <= req_tdata;
                  state_ff  <= F_READ;
               end
            end
            F_READ: begin
               sq_new_ff <= SQ_W'($signed(sample_ff) * $signed(sample_ff));
               sq_old_ff <= SQ_W'($signed(ref_rd) * $signed(ref_rd));
               state_ff  <= F_UPD;
            end
            F_UPD: begin
               if (push_ready) begin
                  wsum_ff  <= wsum_in;
                  wsq_ff   <= wsq_in;
                  pis_ff   <= pis_in;
                  prev_ff  <= sample_ff;
                  seen_ff  <= seen_in;
                  ptr_ff   <= ptr_ff + 1'b1;
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

FILE: sv/stsu_queue.sv
// ----------------------------------------------------------------------------
// Trend statistics job queue
// Two-entry queue between the front part and the back part.
// ----------------------------------------------------------------------------
module stsu_queue import stsu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_data
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: sv/stsu_div.sv
// ----------------------------------------------------------------------------
// Trend statistics divider
// Restoring divider, one quotient bit per cycle, with a per-request count of
// quotient bits so that short numerators finish early.
// ----------------------------------------------------------------------------
module stsu_div import stsu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [DIV_CNT_W-1:0] shamt;
   logic [DIV_DEN_W:0]   rem_sh;
   logic [DIV_DEN_W+1:0] diff;

   // align the numerator's top bit with the top of the shift register
   assign shamt  = DIV_CNT_W'(DIV_NUM_W) - req.nbits;
   assign rem_sh = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, den_ff};

   // one trial subtraction per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (req.start) begin
         quo_ff  <= req.num << shamt;
         rem_ff  <= '0;
         den_ff  <= req.den;
         cnt_ff  <= req.nbits;
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         if (!diff[DIV_DEN_W+1]) begin
            rem_ff <= diff[DIV_DEN_W-1:0];
            quo_ff <= {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[DIV_DEN_W-1:0];
            quo_ff <= {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
   assign rsp.rem  = rem_ff;

endmodule

FILE: sv/stsu_back.sv
// ----------------------------------------------------------------------------
// Trend statistics back part
// Takes jobs from the queue and works out mean increase, relative change,
// deviation (square root plus shared divider), switch count and outlier test.
// ----------------------------------------------------------------------------
module stsu_back import stsu_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [FACTOR_W-1:0] band_factor,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  job_type             pop_data,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [111:0]        rsp_tdata,  // mean_positive_increase, relative_percent,
                                           // std_deviation, switch_now, switch_total,
                                           // outlier, outlier_distance, zero fill
   output logic [2:0]          rsp_tuser   // increase_valid, relative_valid,
                                           // deviation_valid
);

   typedef enum logic [3:0] {
      B_IDLE, B_MUL, B_VAR, B_MEAN, B_REL, B_ROOTW, B_STD, B_BAND, B_HW,
      B_DIST0, B_DIST, B_OUT
   } back_state_type;

   typedef enum logic [1:0] {SIGN_NONE, SIGN_NONNEG, SIGN_NEG} sign_type;

   back_state_type state_ff;
   job_type        job_ff;
   div_req_type    div_req_ff;
   div_rsp_type    div_rsp;
   logic [59:0]    prod_sq_ff;
   logic [59:0]    prod_sum_ff;
   logic [30:0]    an_ff;
   logic [30:0]    pxs_ff;
   logic [23:0]    mean_ff;
   logic [15:0]    rel_ff;
   logic [23:0]    stdv_ff;
   logic [33:0]    fs_ff;
   logic [39:0]    hw_ff;
   logic           outl_ff;
   sign_type       last_sign_ff;
   logic [15:0]    switch_cnt_ff;
   logic           rsp_valid_ff;
   logic [111:0]   rsp_data_ff;
   logic [2:0]     rsp_user_ff;
   logic           div_start_in;
   logic           rsp_valid_in;

   // square root unit
   logic [61:0]    sq_op_ff;
   logic [34:0]    sq_rem_ff;
   logic [30:0]    sq_root_ff;
   logic [4:0]     sq_cnt_ff;
   logic           sq_busy_ff;
   logic [34:0]    sq_rem_sh;
   logic [34:0]    sq_trial;
   logic [59:0]    var_val;

   // relative change, distance and switch terms
   logic [SAMPLE_W-1:0] ref_abs;
   logic [SAMPLE_W-1:0] x_abs;
   logic                rel_rnd;
   logic [30:0]         rel_q1;
   logic signed [33:0]  rel_s;
   logic [15:0]         rel_sat;
   logic                div_ready;
   logic signed [42:0]  xs;
   logic signed [42:0]  band_hi;
   logic signed [42:0]  band_lo;
   logic signed [42:0]  dist_d;
   logic                dist_hit;
   logic [42:0]         dist_a;
   logic [23:0]         std_sat;
   logic [25:0]         dist_sat;
   sign_type            new_sign;
   logic                sw_now;
   logic [15:0]         sw_total;
   logic                out_free;

   stsu_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req_ff),
      .rsp   (div_rsp)
   );

   assign pop_ready  = (state_ff == B_IDLE);
   assign div_ready  = !div_req_ff.start && div_rsp.done;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // variance numerator P*sum(x^2) - sum(x)^2
   assign var_val = prod_sq_ff - prod_sum_ff;

   // square root step: bring down two bits, trial subtract
   assign sq_rem_sh = {sq_rem_ff[32:0], sq_op_ff[61:60]};
   assign sq_trial  = {2'b00, sq_root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_busy_ff <= 1'b0;
      end else if (state_ff == B_VAR) begin
         sq_op_ff   <= {var_val, 2'b00};
         sq_rem_ff  <= '0;
         sq_root_ff <= '0;
         sq_cnt_ff  <= 5'd30;
         sq_busy_ff <= 1'b1;
      end else if (sq_busy_ff) begin
         sq_op_ff <= {sq_op_ff[59:0], 2'b00};
         if (sq_rem_sh >= sq_trial) begin
            sq_rem_ff  <= sq_rem_sh - sq_trial;
            sq_root_ff <= {sq_root_ff[29:0], 1'b1};
         end else begin
            sq_rem_ff  <= sq_rem_sh;
            sq_root_ff <= {sq_root_ff[29:0], 1'b0};
         end
         sq_cnt_ff <= sq_cnt_ff - 1'b1;
         if (sq_cnt_ff == 5'd0) begin
            sq_busy_ff <= 1'b0;
         end
      end
   end

   // relative change: round half away from zero, minus 100, fold, saturate; a zero reference gives 0 or a limit
   always_comb begin
      ref_abs = job_ff.ref_sample[SAMPLE_W-1] ? -job_ff.ref_sample : job_ff.ref_sample;
      x_abs   = job_ff.sample[SAMPLE_W-1] ? -job_ff.sample : job_ff.sample;
      rel_rnd = {div_rsp.rem, 1'b0} >= {1'b0, ref_abs};
      rel_q1  = div_rsp.quo[30:0] + 31'(rel_rnd);
      rel_s   = (job_ff.sample[SAMPLE_W-1] != job_ff.ref_sample[SAMPLE_W-1])
                ? -$signed({3'b000, rel_q1}) : $signed({3'b000, rel_q1});
      rel_s   = rel_s - 34'sd100;
      if (($signed(job_ff.sample) > $signed(job_ff.ref_sample)) && (rel_s < 0)) begin
         rel_s = -rel_s;
      end
      if (rel_s > 34'sd32767) begin
         rel_sat = REL_MAX;
      end else if (rel_s < -34'sd32768) begin
         rel_sat = REL_MIN;
      end else begin
         rel_sat = rel_s[15:0];
      end
      if (job_ff.ref_sample == '0) begin
         if (job_ff.sample == '0) begin
            rel_sat = '0;
         end else if (job_ff.sample[SAMPLE_W-1]) begin
            rel_sat = REL_MIN;
         end else begin
            rel_sat = REL_MAX;
         end
      end
   end

   // band test in units of 1/(256*P)
   always_comb begin
      xs       = 43'($signed(pxs_ff)) <<< 8;
      band_hi  = (43'($signed(job_ff.wsum)) <<< 8) + $signed({3'b000, hw_ff});
      band_lo  = (43'($signed(job_ff.wsum)) <<< 8) - $signed({3'b000, hw_ff});
      dist_hit = 1'b0;
      dist_d   = '0;
      if (xs > band_hi) begin
         dist_hit = 1'b1;
         dist_d   = xs - band_hi;
      end else if (xs < band_lo) begin
         dist_hit = 1'b1;
         dist_d   = band_lo - xs;
      end
      dist_a   = unsigned'(dist_d) + {30'd0, job_ff.period, 7'd0};
      std_sat  = (div_rsp.quo > DIV_NUM_W'(STD_MAX)) ? STD_MAX : div_rsp.quo[23:0];
      dist_sat = (div_rsp.quo > DIV_NUM_W'(DIST_MAX)) ? DIST_MAX : div_rsp.quo[25:0];
   end

   // tendency switch against the previous valid relative change
   always_comb begin
      new_sign = rel_ff[15] ? SIGN_NEG : SIGN_NONNEG;
      sw_now   = job_ff.inc_valid && (last_sign_ff != SIGN_NONE)
                 && (last_sign_ff != new_sign);
      sw_total = (sw_now && (switch_cnt_ff != SWITCH_MAX))
                 ? switch_cnt_ff + 1'b1 : switch_cnt_ff;
   end

   // divider start pulse and result valid for the next cycle
   always_comb begin
      case (state_ff)
         B_VAR:   div_start_in = 1'b1;
         B_MEAN:  div_start_in = div_ready;
         B_ROOTW: div_start_in = !sq_busy_ff;
         B_DIST0: div_start_in = 1'b1;
         default: div_start_in = 1'b0;
      endcase
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if ((state_ff == B_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   // sequence one job through the shared units and register the result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= B_IDLE;
         div_req_ff.start <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         last_sign_ff     <= SIGN_NONE;
         switch_cnt_ff    <= '0;
      end else begin
         div_req_ff.start <= div_start_in;
         rsp_valid_ff     <= rsp_valid_in;
         case (state_ff)
            B_IDLE: begin
               if (pop_valid) begin
                  job_ff   <= pop_data;
                  state_ff <= B_MUL;
               end
            end
            B_MUL: begin
               prod_sq_ff  <= 60'(job_ff.period * job_ff.wsq);
               prod_sum_ff <= 60'($signed(job_ff.wsum) * $signed(job_ff.wsum));
               an_ff       <= 31'(x_abs * 7'd100);
               pxs_ff      <= 31'($signed({1'b0, job_ff.period}) * $signed(job_ff.sample));
               state_ff    <= B_VAR;
            end
            B_VAR: begin
               div_req_ff.num   <= DIV_NUM_W'(32'(job_ff.pis) + 32'(job_ff.period[WLEN_W-1:1]));
               div_req_ff.den   <= DIV_DEN_W'(job_ff.period);
               div_req_ff.nbits <= DIV_BITS_MEAN;
               state_ff         <= B_MEAN;
            end
            B_MEAN: begin
               if (div_ready) begin
                  mean_ff          <= div_rsp.quo[23:0];
                  div_req_ff.num   <= DIV_NUM_W'(an_ff);
                  div_req_ff.den   <= ref_abs;
                  div_req_ff.nbits <= DIV_BITS_REL;
                  state_ff         <= B_REL;
               end
            end
            B_REL: begin
               if (div_ready) begin
                  rel_ff   <= rel_sat;
                  state_ff <= B_ROOTW;
               end
            end
            B_ROOTW: begin
               if (!sq_busy_ff) begin
                  div_req_ff.num   <= DIV_NUM_W'(32'(sq_root_ff) + 32'(job_ff.period));
                  div_req_ff.den   <= DIV_DEN_W'({job_ff.period, 1'b0});
                  div_req_ff.nbits <= DIV_BITS_STD;
                  state_ff         <= B_STD;
               end
            end
            B_STD: begin
               if (div_ready) begin
                  stdv_ff  <= std_sat;
                  state_ff <= B_BAND;
               end
            end
            B_BAND: begin
               fs_ff    <= band_factor * stdv_ff;
               state_ff <= B_HW;
            end
            B_HW: begin
               hw_ff    <= fs_ff * job_ff.period;
               state_ff <= B_DIST0;
            end
            B_DIST0: begin
               outl_ff          <= dist_hit;
               div_req_ff.num   <= DIV_NUM_W'(dist_a[42:8]);
               div_req_ff.den   <= DIV_DEN_W'(job_ff.period);
               div_req_ff.nbits <= DIV_BITS_DIST;
               state_ff         <= B_DIST;
            end
            B_DIST: begin
               if (div_ready) begin
                  state_ff <= B_OUT;
               end
            end
            B_OUT: begin
               if (out_free) begin
                  rsp_user_ff  <= {job_ff.dev_valid, job_ff.inc_valid, job_ff.inc_valid};
                  rsp_data_ff  <= {4'd0,
                                   (job_ff.dev_valid && outl_ff) ? dist_sat : 26'd0,
                                   job_ff.dev_valid && outl_ff,
                                   sw_total,
                                   sw_now,
                                   job_ff.dev_valid ? stdv_ff : 24'd0,
                                   job_ff.inc_valid ? rel_ff : 16'd0,
                                   job_ff.inc_valid ? mean_ff : 24'd0};
                  if (job_ff.inc_valid) begin
                     last_sign_ff <= new_sign;
                  end
                  switch_cnt_ff <= sw_total;
                  state_ff      <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

FILE: sv/sliding_window_trend_stats_unit.sv
// ----------------------------------------------------------------------------
// Sliding window trend statistics unit
// Moving-window mean increase, relative change, deviation, tendency switches
// and band outlier test for a stream of signed Q16.8 samples.
// ----------------------------------------------------------------------------
// Each sample gives one result. The back part runs four divisions of 31 to
// 35 steps each on one shared bit-serial divider, with the 31-step square
// root overlapping the first. The front part updates the window through its
// capture, read-and-square and update states, and a two-entry job queue
// lets it take the following samples while the back part works. The back
// part sets the sustained rate: it takes the next job only once it has
// registered the result of the last one, which a result stall delays.
// Writing window_length restarts the window; switch state and count are kept.
// Write configuration only while idle.
// ----------------------------------------------------------------------------
module sliding_window_trend_stats_unit import stsu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,   // sample
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [111:0]          rsp_tdata,   // mean_positive_increase [23:0],
                                              // relative_percent [39:24],
                                              // std_deviation [63:40], switch_now [64],
                                              // switch_total [80:65], outlier [81],
                                              // outlier_distance [107:82], zero fill
   output logic [2:0]            rsp_tuser,   // increase_valid, relative_valid,
                                              // deviation_valid
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [WLEN_W-1:0]   window_length_ff;
   logic [FACTOR_W-1:0] band_factor_ff;
   logic [WLEN_W-1:0]   period;
   logic                csr_write;
   logic                restart;
   logic                push_valid;
   logic                push_ready;
   job_type             push_data;
   logic                pop_valid;
   logic                pop_ready;
   job_type             pop_data;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign restart   = csr_write && (csr_index == CSR_WINDOW_LENGTH);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WLEN_W'(7);
         band_factor_ff   <= FACTOR_W'(481);
      end else if (csr_write) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: window_length_ff <= csr_data[WLEN_W-1:0];
            CSR_BAND_FACTOR:   band_factor_ff   <= csr_data[FACTOR_W-1:0];
            default: ;
         endcase
      end
   end

   // effective window: zero acts as one, clamp to MAX_WINDOW, one below the ring size
   always_comb begin
      if (window_length_ff == '0) begin
         period = WLEN_W'(1);
      end else if (window_length_ff > WLEN_W'(MAX_WINDOW)) begin
         period = WLEN_W'(MAX_WINDOW);
      end else begin
         period = window_length_ff;
      end
   end

   stsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .period     (period),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   stsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   stsu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .band_factor (band_factor_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // front part takes one sample at a time
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("front accepted back-to-back samples");

   // increase and relative flags agree, and a full increase window implies a full sample window
   a_valid_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == rsp_tuser[1]) && (!rsp_tuser[0] || rsp_tuser[2]))
      else $error("inconsistent validity flags");

   // an outlier needs a deviation, a switch needs a relative change
   a_gated_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[81] || rsp_tuser[2]) && (!rsp_tdata[64] || rsp_tuser[1]))
      else $error("result field set while its window is not full");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trend statistics unit testbench
// Streams signed Q16.8 samples through several window and band settings,
// predicts every result field from a behavioral copy of the window state and
// compares each result transfer in order against the predicted one.
// ----------------------------------------------------------------------------
module tb import stsu_pkg::*; ();

   typedef struct {
      bit          inc_valid;
      bit          rel_valid;
      bit          dev_valid;
      logic [23:0] mean_inc;
      logic [15:0] rel_pct;
      logic [23:0] std_dev;
      bit          switch_now;
      logic [15:0] switch_total;
      bit          outlier;
      logic [25:0] distance;
   } trend_result_type;

   localparam int SIGN_NONE   = 0;
   localparam int SIGN_NONNEG = 1;
   localparam int SIGN_NEG    = 2;

   // --------------------------------------------------------------------------
   // Scoreboard: window predictor plus queue of predicted results
   // --------------------------------------------------------------------------
   class trend_scoreboard;
      longint         sample_ring[RING_DEPTH];
      longint         increase_ring[RING_DEPTH];
      int             samples_seen;
      int             write_pos;
      longint         prev_sample;
      longint         win_sum;
      longint unsigned win_sq_sum;
      longint         pos_inc_sum;
      int             last_sign;
      int             switch_count;
      int             win_len;
      int             band_factor;
      trend_result_type pending_results[$];
      int             fail_count;
      int             sample_count;
      int             outlier_count;
      int             zero_ref_count;

      function new();
         restart();
         last_sign    = SIGN_NONE;
         switch_count = 0;
         win_len      = 7;
         band_factor  = 481;
      endfunction

      function void restart();
         samples_seen = 0;
         write_pos    = 0;
         prev_sample  = 0;
         win_sum      = 0;
         win_sq_sum   = 0;
         pos_inc_sum  = 0;
      endfunction

      function void set_reg(logic idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_WINDOW_LENGTH) begin
            win_len = data[5:0];
            restart();
         end else begin
            band_factor = data;
         end
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res;
         longint unsigned b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      function longint percent_change(longint x, longint ref_x);
         longint num, an, ad, q, rm, r;
         if (ref_x == 0) begin
            zero_ref_count++;
            return x > 0 ? 32767 : (x < 0 ? -32768 : 0);
         end
         num = x * 100;
         an  = num < 0 ? -num : num;
         ad  = ref_x < 0 ? -ref_x : ref_x;
         q   = an / ad;
         rm  = an % ad;
         if (2 * rm >= ad) q++;
         r = ((num < 0) != (ref_x < 0)) ? -q : q;
         r -= 100;
         if (x > ref_x && r < 0) r = -r;
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         return r;
      endfunction

      // predict the result of one accepted sample
      function void note_sample(logic [SAMPLE_W-1:0] raw);
         trend_result_type e;
         int p, n, pos, old, sgn;
         longint x, ref_x, d, rel, xs, ms, hw, gap;
         longint unsigned v, stdv;
         p = (win_len == 0) ? 1 : (win_len > MAX_WINDOW ? MAX_WINDOW : win_len);
         n = samples_seen;
         pos = write_pos % RING_DEPTH;
         old = (pos + RING_DEPTH - p) % RING_DEPTH;
         x = longint'($signed(raw));
         ref_x = 0;
         e = '{default: 0};
         e.inc_valid = (n >= p);
         e.rel_valid = e.inc_valid;
         e.dev_valid = (n + 1 >= p);
         sample_count++;

         // retire the oldest sample and increase, then insert the new ones
         if (n >= p) begin
            ref_x = sample_ring[old];
            win_sum -= ref_x;
            win_sq_sum -= longint'(ref_x * ref_x);
         end
         if (n >= 1) begin
            d = x - prev_sample;
            if (n >= p + 1 && increase_ring[old] > 0) pos_inc_sum -= increase_ring[old];
            if (d > 0) pos_inc_sum += d;
            increase_ring[pos] = d;
         end
         sample_ring[pos] = x;
         win_sum += x;
         win_sq_sum += longint'(x * x);
         prev_sample = x;
         write_pos = (pos + 1) % RING_DEPTH;
         if (n < RING_DEPTH) samples_seen = n + 1;

         if (e.inc_valid) begin
            e.mean_inc = (pos_inc_sum + p / 2) / p;
            rel = percent_change(x, ref_x);
            e.rel_pct = rel[15:0];
            sgn = rel < 0 ? SIGN_NEG : SIGN_NONNEG;
            if (last_sign != SIGN_NONE && last_sign != sgn) begin
               e.switch_now = 1;
               if (switch_count < 65535) switch_count++;
            end
            last_sign = sgn;
         end
         e.switch_total = switch_count[15:0];

         if (e.dev_valid) begin
            v = longint'(p) * win_sq_sum - longint'(win_sum * win_sum);
            stdv = (int_sqrt(4 * v) + p) / (2 * p);
            if (stdv > 16777215) stdv = 16777215;
            e.std_dev = stdv[23:0];
            xs = 256 * longint'(p) * x;
            ms = 256 * win_sum;
            hw = longint'(band_factor) * longint'(stdv) * p;
            gap = 0;
            if (xs > ms + hw) gap = xs - (ms + hw);
            else if (xs < ms - hw) gap = (ms - hw) - xs;
            if (gap > 0) begin
               e.outlier = 1;
               outlier_count++;
               gap = (gap + 128 * p) / (256 * p);
               if (gap > 67108863) gap = 67108863;
               e.distance = gap[25:0];
            end
         end
         pending_results.insert(pending_results.size(), e);
      endfunction

      function void report(string field, longint unsigned exp_v, longint unsigned act_v);
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $realtime, field,
                  exp_v, act_v);
         fail_count++;
      endfunction

      // compare one result transfer with the oldest prediction
      function void check(logic [111:0] data, logic [2:0] user);
         trend_result_type e;
         if (pending_results.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual %h", $realtime, data);
            fail_count++;
            return;
         end
         e = pending_results.pop_front();
         if (user[0] !== e.inc_valid) report("increase_valid", e.inc_valid, user[0]);
         if (user[1] !== e.rel_valid) report("relative_valid", e.rel_valid, user[1]);
         if (user[2] !== e.dev_valid) report("deviation_valid", e.dev_valid, user[2]);
         if (data[23:0] !== e.mean_inc) report("mean_positive_increase", e.mean_inc, data[23:0]);
         if (data[39:24] !== e.rel_pct) report("relative_percent", e.rel_pct, data[39:24]);
         if (data[63:40] !== e.std_dev) report("std_deviation", e.std_dev, data[63:40]);
         if (data[64] !== e.switch_now) report("switch_now", e.switch_now, data[64]);
         if (data[80:65] !== e.switch_total) report("switch_total", e.switch_total, data[80:65]);
         if (data[81] !== e.outlier) report("outlier", e.outlier, data[81]);
         if (data[107:82] !== e.distance) report("outlier_distance", e.distance, data[107:82]);
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [111:0]          rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic                  csr_index = CSR_WINDOW_LENGTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   trend_scoreboard sb = new();
   bit      no_idle = 0;
   longint  walk_level = 0;

   sliding_window_trend_stats_unit dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // random result backpressure
   always @(negedge clock)
      rsp_tready <= no_idle || ($urandom_range(99) >= 36);

   // check every result transfer
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata, rsp_tuser);

   // transfer one sample, with a random gap ahead of it
   task automatic send_sample(logic [SAMPLE_W-1:0] s);
      @(negedge clock);
      if (!no_idle && $urandom_range(99) < 36) begin
         req_tvalid <= 0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      sb.note_sample(s);
   endtask

   // hold the input until every predicted result has arrived
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // mix of random walks, spikes, flat runs, full-range and extreme samples
   function automatic logic [SAMPLE_W-1:0] next_sample();
      int sel;
      sel = $urandom_range(99);
      if (sel < 40) begin
         walk_level += $signed($urandom_range(2000)) - 1000;
         if (walk_level > 8388607 || walk_level < -8388608) walk_level = 0;
         return walk_level[23:0];
      end else if (sel < 60) begin
         return $urandom_range(99) < 8 ? SAMPLE_W'($urandom) : walk_level[23:0];
      end else if (sel < 80) begin
         return SAMPLE_W'($urandom);
      end else if (sel < 90) begin
         return '0;
      end else begin
         return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      end
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) send_sample(next_sample());
   endtask

   initial begin
      logic [SAMPLE_W-1:0] directed[$];
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed samples at the reset window of seven: zero references, extremes
      directed = '{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
                   24'h7FFFFF, 24'h800000, 24'h0, 24'd5, -24'sd5, 24'h7FFFFF,
                   24'd256, 24'd512, 24'd256, -24'sd256, 24'h0, 24'd1, 24'd100,
                   24'h800000};
      foreach (directed[i]) send_sample(directed[i]);
      random_phase(220);
      drain();

      write_reg(CSR_WINDOW_LENGTH, 10'd1);
      write_reg(CSR_BAND_FACTOR, 10'd0);
      random_phase(200);
      drain();

      write_reg(CSR_WINDOW_LENGTH, 10'd63);
      write_reg(CSR_BAND_FACTOR, 10'd1023);
      no_idle = 1;
      random_phase(260);
      no_idle = 0;
      drain();

      // zero window length behaves as one
      write_reg(CSR_WINDOW_LENGTH, 10'd0);
      write_reg(CSR_BAND_FACTOR, 10'd256);
      random_phase(200);
      drain();

      write_reg(CSR_WINDOW_LENGTH, 10'd2);
      write_reg(CSR_BAND_FACTOR, 10'd64);
      random_phase(200);
      drain();

      write_reg(CSR_WINDOW_LENGTH, CSR_DATA_W'($urandom_range(3, 62)));
      write_reg(CSR_BAND_FACTOR, CSR_DATA_W'($urandom_range(1023)));
      random_phase(150);
      drain();
      repeat (200) @(posedge clock);

      $display("Covered %0d samples over six window settings, %0d outliers, %0d switches,",
               sb.sample_count, sb.outlier_count, sb.switch_count);
      $display("%0d zero-reference changes, %0d results still outstanding.",
               sb.zero_ref_count, sb.pending_results.size());
      if (sb.fail_count == 0 && sb.pending_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // hard stop
   initial begin
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

FILE: files.f
sv/stsu_pkg.sv
sv/stsu_ram.sv
sv/stsu_front.sv
sv/stsu_queue.sv
sv/stsu_div.sv
sv/stsu_back.sv
sv/sliding_window_trend_stats_unit.sv
tb/tb.sv
